[src/dfr_pkg.sv]
package dfr_pkg;

  // Fixed frame layout.
  localparam int unsigned PARAM_BYTES = 10;
  localparam int unsigned STORE_DEPTH = PARAM_BYTES - 1;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  localparam int unsigned IDX_W       = 14;
  localparam int unsigned CMD_DEPTH   = 2;

  // Default frame size limits.
  localparam int unsigned MAX_COLUMNS_DEF = 128;
  localparam int unsigned MAX_ROWS_DEF    = 128;

  // Header bytes.
  localparam logic [7:0] SYNC_0 = 8'hAA;
  localparam logic [7:0] SYNC_1 = 8'hBB;
  localparam logic [7:0] SYNC_2 = 8'hCC;

  // Pixel levels after thresholding.
  localparam logic [7:0] PIX_LOW  = 8'h00;
  localparam logic [7:0] PIX_HIGH = 8'hFF;

  // Header hunt progress; HDR_DONE means the payload is being taken.
  localparam logic [1:0] HDR_NONE = 2'd0;
  localparam logic [1:0] HDR_AA   = 2'd1;
  localparam logic [1:0] HDR_BB   = 2'd2;
  localparam logic [1:0] HDR_DONE = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FRAME_COLUMNS    = 3'd0;
  localparam logic [2:0] CFG_FRAME_ROWS       = 3'd1;
  localparam logic [2:0] CFG_BINARY_THRESHOLD = 3'd2;
  localparam logic [2:0] CFG_IMAGE_ENABLE     = 3'd3;
  localparam logic [2:0] CFG_PARAMS_ENABLE    = 3'd4;

  // Input kinds.
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Result kinds.
  localparam logic [1:0] RES_BINARY = 2'd0;
  localparam logic [1:0] RES_RAW    = 2'd1;
  localparam logic [1:0] RES_RECORD = 2'd2;

  typedef enum logic [1:0] {
    CMD_BIN_PIXEL,
    CMD_RAW_PIXEL,
    CMD_STORE,
    CMD_RECORD
  } cmd_op_e;

  // Work handed from the front part to the back part.
  typedef struct packed {
    cmd_op_e          op;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic             frame_end;
  } cmd_t;

  typedef struct packed {
    logic [7:0] frame_columns;
    logic [7:0] frame_rows;
    logic [7:0] binary_threshold;
    logic       image_enable;
    logic       params_enable;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       raw_pixel;
    logic [7:0]       binary_pixel;
    logic             frame_end;
    logic [15:0]      encoder_value;
    logic [15:0]      motor_value;
    logic [15:0]      servo_value;
    logic [7:0]       extra_one;
    logic [7:0]       extra_two;
    logic [7:0]       extra_three;
    logic [7:0]       extra_four;
  } out_item_t;

endpackage

[src/dfr_fifo.sv]
module dfr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [Aw-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [Cw-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == Cw'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[src/dfr_front.sv]
module dfr_front #(
  parameter int unsigned MaxColumns = dfr_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MaxRows    = dfr_pkg::MAX_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dfr_pkg::cfg_t     cfg_i,
  input  logic              take_i,
  input  dfr_pkg::in_item_t item_i,
  output logic              cmd_push_o,
  output dfr_pkg::cmd_t     cmd_o
);

  // Register fields are 8 bits, so a limit above 255 never clips.
  localparam int unsigned ColCap = (MaxColumns < 255) ? MaxColumns : 255;
  localparam int unsigned RowCap = (MaxRows < 255) ? MaxRows : 255;
  localparam int unsigned TotW   = $clog2(ColCap * RowCap + 1);
  localparam int unsigned PosW   = $clog2(ColCap * RowCap + dfr_pkg::PARAM_BYTES + 1);

  logic [1:0]      hdr_q, hdr_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      cols_c, rows_c;
  logic [15:0]     prod;
  logic [PosW-1:0] total;
  logic [PosW-1:0] pos_inc;
  logic [PosW-1:0] poff;
  logic            at_end_pix;
  logic [7:0]      b;

  // Frame size from the clipped register values.
  assign cols_c  = (cfg_i.frame_columns > 8'(ColCap)) ? 8'(ColCap) : cfg_i.frame_columns;
  assign rows_c  = (cfg_i.frame_rows > 8'(RowCap)) ? 8'(RowCap) : cfg_i.frame_rows;
  assign prod    = cols_c * rows_c;
  assign total   = PosW'(prod[TotW-1:0]);
  assign pos_inc = pos_q + 1'b1;
  assign poff    = pos_q - total;
  assign at_end_pix = (pos_inc == total);
  assign b       = item_i.rx_byte;

  // Header hunt, payload position and command selection.
  always_comb begin
    hdr_d           = hdr_q;
    pos_d           = pos_q;
    cmd_push_o      = 1'b0;
    cmd_o.op        = dfr_pkg::CMD_STORE;
    cmd_o.data      = b;
    cmd_o.index     = dfr_pkg::IDX_W'(pos_q);
    cmd_o.frame_end = 1'b0;
    if (take_i) begin
      priority if (item_i.kind == dfr_pkg::KIND_RESTART) begin
        hdr_d = dfr_pkg::HDR_NONE;
        pos_d = '0;
      end else if (!cfg_i.image_enable && !cfg_i.params_enable) begin
        hdr_d = hdr_q;
      end else if (hdr_q != dfr_pkg::HDR_DONE) begin
        if (hdr_q == dfr_pkg::HDR_NONE && b == dfr_pkg::SYNC_0) begin
          hdr_d = dfr_pkg::HDR_AA;
        end else if (hdr_q == dfr_pkg::HDR_AA && b == dfr_pkg::SYNC_1) begin
          hdr_d = dfr_pkg::HDR_BB;
        end else if (hdr_q == dfr_pkg::HDR_BB && b == dfr_pkg::SYNC_2) begin
          hdr_d = dfr_pkg::HDR_DONE;
        end
      end else if (!cfg_i.params_enable) begin
        // Image only: thresholded pixels.
        if (pos_q >= total) begin
          hdr_d = dfr_pkg::HDR_NONE;
          pos_d = '0;
        end else begin
          cmd_push_o      = 1'b1;
          cmd_o.op        = dfr_pkg::CMD_BIN_PIXEL;
          cmd_o.frame_end = at_end_pix;
          if (at_end_pix) begin
            hdr_d = dfr_pkg::HDR_NONE;
            pos_d = '0;
          end else begin
            pos_d = pos_inc;
          end
        end
      end else if (cfg_i.image_enable && pos_q < total) begin
        // Combined mode, pixel part: raw pixels.
        cmd_push_o = 1'b1;
        cmd_o.op   = dfr_pkg::CMD_RAW_PIXEL;
        pos_d      = pos_inc;
      end else begin
        // Parameter bytes, alone or after the pixels.
        if (!cfg_i.image_enable) begin
          poff_sel(pos_q);
        end else begin
          poff_sel(poff);
        end
      end
    end
  end

  // Parameter byte handling at a given offset into the parameter block.
  function automatic void poff_sel(input logic [PosW-1:0] p);
    if (p >= PosW'(dfr_pkg::PARAM_BYTES)) begin
      hdr_d = dfr_pkg::HDR_NONE;
      pos_d = '0;
    end else if (p < PosW'(dfr_pkg::STORE_DEPTH)) begin
      cmd_push_o  = 1'b1;
      cmd_o.op    = dfr_pkg::CMD_STORE;
      cmd_o.index = dfr_pkg::IDX_W'(p);
      pos_d       = pos_inc;
    end else begin
      cmd_push_o      = 1'b1;
      cmd_o.op        = dfr_pkg::CMD_RECORD;
      cmd_o.frame_end = 1'b1;
      hdr_d           = dfr_pkg::HDR_NONE;
      pos_d           = '0;
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= dfr_pkg::HDR_NONE;
      pos_q <= '0;
    end else begin
      hdr_q <= hdr_d;
      pos_q <= pos_d;
    end
  end

endmodule

[src/dfr_back.sv]
module dfr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         threshold_i,
  input  logic               cmd_valid_i,
  input  dfr_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  logic               pop,
  output dfr_pkg::out_item_t out_o
);

  logic [7:0]         store_q [dfr_pkg::STORE_DEPTH];
  logic               valid_q, valid_d;
  dfr_pkg::out_item_t out_q, out_d;
  logic               is_store;
  logic               emit;
  logic [dfr_pkg::STORE_AW-1:0] waddr;

  assign is_store  = (cmd_i.op == dfr_pkg::CMD_STORE);
  assign cmd_pop_o = cmd_valid_i && (is_store || !valid_q || pop);
  assign emit      = cmd_pop_o && !is_store;
  assign waddr     = cmd_i.index[dfr_pkg::STORE_AW-1:0];
  assign empty     = !valid_q;
  assign out_o     = out_q;

  // Result assembly for the command at the head of the queue.
  always_comb begin
    out_d             = '0;
    out_d.frame_end   = cmd_i.frame_end;
    unique case (cmd_i.op)
      dfr_pkg::CMD_BIN_PIXEL: begin
        out_d.result_kind  = dfr_pkg::RES_BINARY;
        out_d.pixel_index  = cmd_i.index;
        out_d.raw_pixel    = cmd_i.data;
        out_d.binary_pixel = (cmd_i.data < threshold_i) ? dfr_pkg::PIX_LOW
                                                        : dfr_pkg::PIX_HIGH;
      end
      dfr_pkg::CMD_RAW_PIXEL: begin
        out_d.result_kind = dfr_pkg::RES_RAW;
        out_d.pixel_index = cmd_i.index;
        out_d.raw_pixel   = cmd_i.data;
      end
      dfr_pkg::CMD_RECORD: begin
        out_d.result_kind   = dfr_pkg::RES_RECORD;
        out_d.encoder_value = {store_q[0], store_q[1]};
        out_d.motor_value   = {store_q[2], store_q[3]};
        out_d.servo_value   = {store_q[4], store_q[5]};
        out_d.extra_one     = store_q[6];
        out_d.extra_two     = store_q[7];
        out_d.extra_three   = store_q[8];
        out_d.extra_four    = cmd_i.data;
      end
      default: begin
        out_d.result_kind = dfr_pkg::RES_RAW;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    if (emit) begin
      valid_d = 1'b1;
    end else if (pop) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Output payload and parameter byte store.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
    if (cmd_pop_o && is_store) begin
      store_q[waddr] <= cmd_i.data;
    end
  end

`ifndef SYNTH
  // A parameter record always closes its frame.
  a_record_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_q.result_kind == dfr_pkg::RES_RECORD) |-> out_q.frame_end)
    else $error("record without frame end");

  // Stores only land inside the parameter byte store.
  a_store_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && is_store) |-> (cmd_i.index < dfr_pkg::IDX_W'(dfr_pkg::STORE_DEPTH)))
    else $error("parameter store address out of range");

  // A thresholded pixel is either fully dark or fully bright.
  a_bin_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_q.result_kind == dfr_pkg::RES_BINARY)
      |-> (out_q.binary_pixel == dfr_pkg::PIX_LOW || out_q.binary_pixel == dfr_pkg::PIX_HIGH))
    else $error("binary pixel level invalid");

  // A waiting result is replaced only after it was taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !pop) |=> (valid_q && $stable(out_q)))
    else $error("waiting result overwritten");
`endif

endmodule

[src/sync_framed_image_param_deframer.sv]
// Channel   Direction  Handshake            Payload
// input     in         push / full          in_item_i  (kind, rx_byte)
// result    out        pop / empty          out_item_o (pixel or parameter record)
// config    in         cfg_we_i             cfg_index_i, cfg_data_i
//
// Each beat is classified in the cycle it is accepted; one beat per cycle is taken while full is low.
// A result passes from its input beat through the command queue and the result register to the result ports.
// A two-entry command queue parts the classifier from the result register.
// A stall on the result side fills the queue and then raises full.
// Reset clears the header hunt and the payload position and loads the config register defaults.
module sync_framed_image_param_deframer #(
  parameter int unsigned MAX_COLUMNS = dfr_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = dfr_pkg::MAX_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  dfr_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output dfr_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  dfr_pkg::cfg_t cfg_q, cfg_d;
  dfr_pkg::cmd_t cmd_in, cmd_out;
  logic          take;
  logic          cmd_push, cmd_pop, cmd_empty;

  assign take = push && !full;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        dfr_pkg::CFG_FRAME_COLUMNS:    cfg_d.frame_columns    = cfg_data_i;
        dfr_pkg::CFG_FRAME_ROWS:       cfg_d.frame_rows       = cfg_data_i;
        dfr_pkg::CFG_BINARY_THRESHOLD: cfg_d.binary_threshold = cfg_data_i;
        dfr_pkg::CFG_IMAGE_ENABLE:     cfg_d.image_enable     = cfg_data_i[0];
        dfr_pkg::CFG_PARAMS_ENABLE:    cfg_d.params_enable    = cfg_data_i[0];
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_columns    <= 8'd20;
      cfg_q.frame_rows       <= 8'd20;
      cfg_q.binary_threshold <= 8'd128;
      cfg_q.image_enable     <= 1'b1;
      cfg_q.params_enable    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Header hunt and classification.
  dfr_front #(
    .MaxColumns(MAX_COLUMNS),
    .MaxRows   (MAX_ROWS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .take_i    (take),
    .item_i    (in_item_i),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in)
  );

  // Command queue between the two parts.
  dfr_fifo #(
    .Width($bits(dfr_pkg::cmd_t)),
    .Depth(dfr_pkg::CMD_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_out),
    .empty_o(cmd_empty)
  );

  // Parameter store, thresholding and result register.
  dfr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .threshold_i(cfg_q.binary_threshold),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_item_o)
  );

endmodule
